// File: rtl/pf_pkg.sv
// Shared constants, types and helpers for the Playfair digraph cipher.
package pf_pkg;

  localparam int SIDE    = 5;
  localparam int CELLS   = SIDE * SIDE;
  localparam int CODE_W  = 5;
  localparam int IDX_W   = $clog2(SIDE);
  localparam int FLAT_W  = CELLS * CODE_W;
  localparam int UPPER_W = 50;
  localparam int MID_W   = 50;
  localparam int BOT_W   = 25;
  localparam int CFG_W   = 50;
  localparam int REG_IDX_W = 2;

  localparam logic [CODE_W-1:0] LETTER_I = CODE_W'(8);
  localparam logic [CODE_W-1:0] LETTER_J = CODE_W'(9);
  localparam logic [CODE_W-1:0] LETTER_X = CODE_W'(23);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_UPPER  = 2'd0,
    REG_MIDDLE = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_MODE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [UPPER_W-1:0] upper;
    logic [MID_W-1:0]   middle;
    logic [BOT_W-1:0]   bottom;
    logic               decrypt;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
    logic              fin;
  } pair_t;

  // Step a row or column index one place forward (encrypt) or back (decrypt),
  // wrapping around the square.
  function automatic logic [IDX_W-1:0] shift_idx(input logic [IDX_W-1:0] v,
                                                 input logic dec);
    logic [IDX_W-1:0] last;
    last = IDX_W'(SIDE - 1);
    if (dec) begin
      shift_idx = (v == '0) ? last : v - IDX_W'(1);
    end else begin
      shift_idx = (v == last) ? '0 : v + IDX_W'(1);
    end
  endfunction

endpackage

// File: rtl/pf_xform.sv
// Digraph transform: locates both letters in the key square and applies the rules.
module pf_xform (
  input  pf_pkg::cfg_t                cfg,
  input  pf_pkg::pair_t               pair,
  output logic [pf_pkg::CODE_W-1:0]   first_out,
  output logic [pf_pkg::CODE_W-1:0]   second_out
);

  logic [pf_pkg::FLAT_W-1:0] flat;
  logic [pf_pkg::CODE_W-1:0] grid [0:pf_pkg::SIDE-1][0:pf_pkg::SIDE-1];
  logic [pf_pkg::IDX_W-1:0]  ra, ca, rb, cb;
  logic [pf_pkg::IDX_W-1:0]  ora, oca, orb, ocb;

  // Cells past the three registers read as zero.
  assign flat = pf_pkg::FLAT_W'({cfg.bottom, cfg.middle, cfg.upper});

  always_comb begin
    for (int r = 0; r < pf_pkg::SIDE; r++) begin
      for (int c = 0; c < pf_pkg::SIDE; c++) begin
        grid[r][c] = flat[(r * pf_pkg::SIDE + c) * pf_pkg::CODE_W +: pf_pkg::CODE_W];
      end
    end
  end

  // A letter not in the square sits at row 0, column 0; the highest matching
  // cell wins when a letter appears more than once.
  always_comb begin
    ra = '0;
    ca = '0;
    rb = '0;
    cb = '0;
    for (int k = 0; k < pf_pkg::CELLS; k++) begin
      if (flat[k * pf_pkg::CODE_W +: pf_pkg::CODE_W] == pair.a) begin
        ra = pf_pkg::IDX_W'(k / pf_pkg::SIDE);
        ca = pf_pkg::IDX_W'(k % pf_pkg::SIDE);
      end
      if (flat[k * pf_pkg::CODE_W +: pf_pkg::CODE_W] == pair.b) begin
        rb = pf_pkg::IDX_W'(k / pf_pkg::SIDE);
        cb = pf_pkg::IDX_W'(k % pf_pkg::SIDE);
      end
    end
  end

  always_comb begin
    if (ra == rb) begin
      ora = ra;
      orb = rb;
      oca = pf_pkg::shift_idx(ca, cfg.decrypt);
      ocb = pf_pkg::shift_idx(cb, cfg.decrypt);
    end else if (ca == cb) begin
      ora = pf_pkg::shift_idx(ra, cfg.decrypt);
      orb = pf_pkg::shift_idx(rb, cfg.decrypt);
      oca = ca;
      ocb = cb;
    end else begin
      ora = ra;
      orb = rb;
      oca = cb;
      ocb = ca;
    end
  end

  assign first_out  = grid[ora][oca];
  assign second_out = grid[orb][ocb];

endmodule

// File: rtl/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: pairing, pending queue and output register.
//
// Usage: letters arrive one per beat on the s_ channel, code in s_tdata[4:0]
// (A=0 .. Z=25, J is folded into I), with s_tlast on the last letter of a
// message. Digraphs leave on the m_ channel, first letter in m_tdata[4:0],
// second in m_tdata[9:5], and m_tlast marks the last digraph of a message.
// An X is inserted after a letter that repeats or that is left alone at the
// end of a message, so one input beat yields zero, one or two output beats.
// The key square and the encrypt/decrypt mode are written through the cfg
// port; the user must do so only while no message is in flight (not enforced).
// A completed digraph passes through the pending queue and then the output
// register before it appears on m_. Throughput is one letter per cycle when
// each beat yields at most one digraph and the receiver does not stall; after
// a beat that yields two digraphs, s_tready stays low while the queue drains.
// The limit is the single output register that takes one digraph per cycle,
// while m_ is not stalled, from a two-entry pending queue.
// When the receiver stalls, the output holds its digraph, the queue fills and
// s_tready drops until the queue drains. Reset (synchronous) clears the held
// letter, the queue, the output valid and all configuration registers.
module playfair_digraph_cipher (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [4:0] letter, [7:5] zero
  input  logic                           s_tlast,   // end_of_message
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // [4:0] first_out, [9:5] second_out
  output logic                           m_tlast,   // final_pair
  input  logic                           cfg_we,
  input  logic [pf_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [pf_pkg::CFG_W-1:0]       cfg_data
);

  pf_pkg::cfg_t cfg;

  // Configuration registers; writes are taken at any time but are only
  // meaningful while the block is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (pf_pkg::reg_idx_t'(cfg_index))
        pf_pkg::REG_UPPER:  cfg.upper   <= cfg_data[pf_pkg::UPPER_W-1:0];
        pf_pkg::REG_MIDDLE: cfg.middle  <= cfg_data[pf_pkg::MID_W-1:0];
        pf_pkg::REG_BOTTOM: cfg.bottom  <= cfg_data[pf_pkg::BOT_W-1:0];
        pf_pkg::REG_MODE:   cfg.decrypt <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Letter pairing. The held letter waits for its partner; the pairs that an
  // incoming letter completes are worked out here and go into the queue.
  logic [pf_pkg::CODE_W-1:0] held_letter, held_letter_next;
  logic                      held_valid, held_valid_next;
  logic [pf_pkg::CODE_W-1:0] letter;
  pf_pkg::pair_t             pair0, pair1;
  logic [1:0]                new_cnt;
  logic                      accept;

  assign letter = (s_tdata[4:0] == pf_pkg::LETTER_J) ? pf_pkg::LETTER_I : s_tdata[4:0];
  assign accept = s_tvalid && s_tready;

  always_comb begin
    held_letter_next = held_letter;
    held_valid_next  = held_valid;
    pair0   = '{a: held_letter, b: pf_pkg::LETTER_X, fin: 1'b0};
    pair1   = '{a: letter, b: pf_pkg::LETTER_X, fin: 1'b1};
    new_cnt = 2'd0;
    if (held_valid) begin
      if (held_letter == letter) begin
        // Repeated letter: the held one is padded with X and the new one
        // either waits or, at the end of the message, is padded as well.
        new_cnt = 2'd1;
        if (s_tlast) begin
          new_cnt          = 2'd2;
          held_valid_next  = 1'b0;
          held_letter_next = '0;
        end else begin
          held_letter_next = letter;
        end
      end else begin
        pair0            = '{a: held_letter, b: letter, fin: s_tlast};
        new_cnt          = 2'd1;
        held_valid_next  = 1'b0;
        held_letter_next = '0;
      end
    end else if (s_tlast) begin
      // A lone last letter is padded with X.
      pair0   = '{a: letter, b: pf_pkg::LETTER_X, fin: 1'b1};
      new_cnt = 2'd1;
    end else begin
      held_letter_next = letter;
      held_valid_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter <= '0;
      held_valid  <= 1'b0;
    end else if (accept) begin
      held_letter <= held_letter_next;
      held_valid  <= held_valid_next;
    end
  end

  // Two-entry pending queue. A new beat is taken only when the queue will be
  // empty after this cycle, so new pairs always land in slots zero and one.
  pf_pkg::pair_t pend0, pend1;
  logic [1:0]    pend_cnt;
  logic          out_load;

  assign out_load = (pend_cnt != 2'd0) && (!m_tvalid || m_tready);
  assign s_tready = (pend_cnt == 2'd0) || ((pend_cnt == 2'd1) && out_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= 2'd0;
    end else if (accept) begin
      pend_cnt <= new_cnt;
    end else if (out_load) begin
      pend_cnt <= pend_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend0 <= pair0;
      pend1 <= pair1;
    end else if (out_load) begin
      pend0 <= pend1;
    end
  end

  // Transform of the queue head and the output register.
  logic [pf_pkg::CODE_W-1:0] xf_first, xf_second;

  pf_xform u_xform (
    .cfg        (cfg),
    .pair       (pend0),
    .first_out  (xf_first),
    .second_out (xf_second)
  );

  logic [pf_pkg::CODE_W-1:0] out_first, out_second;
  logic                      out_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_first  <= xf_first;
      out_second <= xf_second;
      out_fin    <= pend0.fin;
    end
  end

  assign m_tdata = {6'd0, out_second, out_first};
  assign m_tlast = out_fin;

  // The queue never holds more than two pairs.
  assert property (@(posedge clk) disable iff (rst) pend_cnt != 2'd3)
    else $error("pending queue overflow");

  // An accepted beat leaves exactly the pairs it produced in the queue.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> pend_cnt == $past(new_cnt))
    else $error("queue count does not match produced pairs");

  // The end of a message never leaves a letter held.
  assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> !held_valid)
    else $error("letter held after end of message");

  // A beat that yields two digraphs blocks the input in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept && new_cnt == 2'd2 |=> !s_tready)
    else $error("input accepted while two pairs pending");

endmodule

// File: tb/playfair_digraph_cipher_test.sv
// Self-checking testbench for the Playfair digraph cipher stream block.
`timescale 1ns / 1ps

module playfair_digraph_cipher_test;

  // One letter beat waiting to be offered on the input stream.
  typedef struct {
    logic [pf_pkg::CODE_W-1:0] code;
    logic                      eom;
  } letter_beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;       // [4:0] letter, [7:5] zero
  logic             s_tlast = 1'b0;     // end_of_message
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [15:0]      m_tdata;            // [4:0] first_out, [9:5] second_out
  logic             m_tlast;            // final_pair
  logic             cfg_we = 1'b0;
  logic [pf_pkg::REG_IDX_W-1:0] cfg_index = pf_pkg::REG_UPPER;
  logic [pf_pkg::CFG_W-1:0]     cfg_data = '0;

  playfair_digraph_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // The predictor keeps its own copy of the key square registers and of the
  // letter held back while it waits for a partner.
  logic [pf_pkg::UPPER_W-1:0] key_upper  = '0;
  logic [pf_pkg::MID_W-1:0]   key_middle = '0;
  logic [pf_pkg::BOT_W-1:0]   key_bottom = '0;
  logic                       decrypt_on = 1'b0;
  logic [pf_pkg::CODE_W-1:0]  held_letter = '0;
  logic                       held_valid = 1'b0;

  letter_beat_t          pending_letters[$];
  pf_pkg::pair_t         expected_digraphs[$];

  int  letters_queued = 0;
  int  letters_accepted = 0;
  int  digraphs_checked = 0;
  int  error_count = 0;
  int  key_settings = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  hold_req = 0;
  int  hold_ack = 0;
  bit  quiet = 1'b0;

  letter_beat_t              next_beat;
  pf_pkg::pair_t             got_pair;
  pf_pkg::pair_t             want_pair;
  logic [pf_pkg::CODE_W-1:0] plan_cells[pf_pkg::CELLS];

  // Code stored in cell k of the key square; cells past the square read as 0.
  function automatic logic [pf_pkg::CODE_W-1:0] key_cell(input int k);
    if (k < 10) return key_upper[pf_pkg::CODE_W*k +: pf_pkg::CODE_W];
    if (k < 20) return key_middle[pf_pkg::CODE_W*(k-10) +: pf_pkg::CODE_W];
    if (k < 25) return key_bottom[pf_pkg::CODE_W*(k-20) +: pf_pkg::CODE_W];
    return '0;
  endfunction

  // Position of a code in the square. A code that is missing sits at the
  // top left corner, and when a code appears twice the later cell counts.
  function automatic void find_cell(input logic [pf_pkg::CODE_W-1:0] code,
                                    output int row, output int col);
    row = 0;
    col = 0;
    for (int k = 0; k < pf_pkg::CELLS; k++) begin
      if (key_cell(k) == code) begin
        row = k / pf_pkg::SIDE;
        col = k % pf_pkg::SIDE;
      end
    end
  endfunction

  // Neighbor index: forward when encrypting, backward when decrypting.
  function automatic int step_index(input int v);
    return decrypt_on ? (v + pf_pkg::SIDE - 1) % pf_pkg::SIDE : (v + 1) % pf_pkg::SIDE;
  endfunction

  // Apply the row, column or rectangle rule to one digraph. A digraph of two
  // equal letters lands on one cell and so takes the row rule.
  function automatic pf_pkg::pair_t cipher_digraph(input logic [pf_pkg::CODE_W-1:0] a,
                                                   input logic [pf_pkg::CODE_W-1:0] b,
                                                   input logic fin);
    int ra, ca, rb, cb, oa, ob;
    pf_pkg::pair_t p;
    find_cell(a, ra, ca);
    find_cell(b, rb, cb);
    if (ra == rb) begin
      oa = ra * pf_pkg::SIDE + step_index(ca);
      ob = rb * pf_pkg::SIDE + step_index(cb);
    end else if (ca == cb) begin
      oa = step_index(ra) * pf_pkg::SIDE + ca;
      ob = step_index(rb) * pf_pkg::SIDE + cb;
    end else begin
      oa = ra * pf_pkg::SIDE + cb;
      ob = rb * pf_pkg::SIDE + ca;
    end
    p.a = key_cell(oa);
    p.b = key_cell(ob);
    p.fin = fin;
    return p;
  endfunction

  // Pair up one accepted letter and queue the digraphs it completes.
  task automatic absorb_letter(input logic [pf_pkg::CODE_W-1:0] code, input logic eom);
    logic [pf_pkg::CODE_W-1:0] l;
    l = (code == pf_pkg::LETTER_J) ? pf_pkg::LETTER_I : code;
    if (held_valid) begin
      if (held_letter == l) begin
        // A doubled letter: the held one is padded with X and the new one
        // is held in turn, or padded at once if it closes the message.
        expected_digraphs.push_back(cipher_digraph(held_letter, pf_pkg::LETTER_X, 1'b0));
        if (eom) begin
          expected_digraphs.push_back(cipher_digraph(l, pf_pkg::LETTER_X, 1'b1));
          held_valid = 1'b0;
          held_letter = '0;
        end else begin
          held_letter = l;
        end
      end else begin
        expected_digraphs.push_back(cipher_digraph(held_letter, l, eom));
        held_valid = 1'b0;
        held_letter = '0;
      end
    end else if (eom) begin
      // A lone letter at the end of a message is padded with X.
      expected_digraphs.push_back(cipher_digraph(l, pf_pkg::LETTER_X, 1'b1));
    end else begin
      held_letter = l;
      held_valid = 1'b1;
    end
  endtask

  // Input driver: offers pending letters, holds a beat until it is taken,
  // and inserts random idle bursts between beats.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_letter(s_tdata[pf_pkg::CODE_W-1:0], s_tlast);
        letters_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_letters.size() != 0) begin
          next_beat = pending_letters.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {3'b000, next_beat.code};
          s_tlast <= next_beat.eom;
          if (!quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 13);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long back-pressure window, counted here so that the output side only
  // has to look at the remaining count.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 80;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output monitor: checks every digraph beat against the oldest prediction
  // and drives tready with random stalls plus the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_pair.a = m_tdata[pf_pkg::CODE_W-1:0];
        got_pair.b = m_tdata[2*pf_pkg::CODE_W-1:pf_pkg::CODE_W];
        got_pair.fin = m_tlast;
        if (expected_digraphs.size() == 0) begin
          $error("unexpected digraph beat: first_out %0d, second_out %0d, final_pair %0d",
                 got_pair.a, got_pair.b, got_pair.fin);
          error_count++;
        end else begin
          want_pair = expected_digraphs.pop_front();
          digraphs_checked++;
          if (got_pair.a !== want_pair.a) begin
            $error("first_out mismatch: expected %0d, got %0d", want_pair.a, got_pair.a);
            error_count++;
          end
          if (got_pair.b !== want_pair.b) begin
            $error("second_out mismatch: expected %0d, got %0d", want_pair.b, got_pair.b);
            error_count++;
          end
          if (got_pair.fin !== want_pair.fin) begin
            $error("final_pair mismatch: expected %0d, got %0d", want_pair.fin, got_pair.fin);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        // Long back-pressure so the pending queue fills and the input stalls.
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Register write; the predictor's copy is masked to the register width.
  task automatic write_reg(input pf_pkg::reg_idx_t idx,
                           input logic [pf_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      pf_pkg::REG_UPPER:  key_upper = value[pf_pkg::UPPER_W-1:0];
      pf_pkg::REG_MIDDLE: key_middle = value[pf_pkg::MID_W-1:0];
      pf_pkg::REG_BOTTOM: key_bottom = value[pf_pkg::BOT_W-1:0];
      pf_pkg::REG_MODE:   decrypt_on = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Pack the planned cells into the three square registers and write them.
  task automatic load_square(input logic decrypt);
    logic [pf_pkg::UPPER_W-1:0] up;
    logic [pf_pkg::MID_W-1:0]   mid;
    logic [pf_pkg::BOT_W-1:0]   bot;
    for (int k = 0; k < 10; k++) up[pf_pkg::CODE_W*k +: pf_pkg::CODE_W] = plan_cells[k];
    for (int k = 0; k < 10; k++) mid[pf_pkg::CODE_W*k +: pf_pkg::CODE_W] = plan_cells[10+k];
    for (int k = 0; k < 5; k++) bot[pf_pkg::CODE_W*k +: pf_pkg::CODE_W] = plan_cells[20+k];
    write_reg(pf_pkg::REG_UPPER, up);
    write_reg(pf_pkg::REG_MIDDLE, mid);
    write_reg(pf_pkg::REG_BOTTOM, pf_pkg::CFG_W'(bot));
    write_reg(pf_pkg::REG_MODE, pf_pkg::CFG_W'(decrypt));
    key_settings++;
  endtask

  // A proper key square: the 25 letters other than J in random order.
  task automatic plan_permuted_square();
    int n;
    int j;
    logic [pf_pkg::CODE_W-1:0] t;
    n = 0;
    for (int c = 0; c < 26; c++) begin
      if (c != int'(pf_pkg::LETTER_J)) begin
        plan_cells[n] = pf_pkg::CODE_W'(c);
        n++;
      end
    end
    for (int k = pf_pkg::CELLS - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = plan_cells[k];
      plan_cells[k] = plan_cells[j];
      plan_cells[j] = t;
    end
  endtask

  task automatic push_letter(input int code, input logic eom);
    letter_beat_t b;
    b.code = pf_pkg::CODE_W'(code);
    b.eom = eom;
    pending_letters.push_back(b);
    letters_queued++;
  endtask

  // Random messages, every one closed by an end-of-message beat. Doubled
  // letters, X and J are favored so that padding gets exercised often, and
  // a few codes outside the alphabet come in as noise.
  task automatic queue_messages(input int count);
    int left;
    int len;
    int code;
    int prev;
    left = count;
    prev = 0;
    while (left > 0) begin
      len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: code = prev;
          3:       code = int'(pf_pkg::LETTER_X);
          4:       code = int'(pf_pkg::LETTER_J);
          5:       code = $urandom_range(26, 31);
          default: code = $urandom_range(0, 25);
        endcase
        push_letter(code, i == len - 1);
        prev = code;
      end
      left -= len;
    end
  endtask

  // Wait until every letter is taken and every digraph has been checked,
  // then let the pipeline settle.
  task automatic wait_drained();
    while (letters_accepted != letters_queued || expected_digraphs.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset square: every cell holds code 0, so A maps to the last cell and
    // every other letter falls back to the top left corner.
    push_letter(0, 1'b0);
    push_letter(0, 1'b1);
    push_letter(7, 1'b0);
    push_letter(12, 1'b1);
    key_settings++;
    wait_drained();

    // Directed letters on a proper square.
    plan_permuted_square();
    load_square(1'b0);
    push_letter(0, 1'b0);                           // A and Z, the alphabet extremes
    push_letter(25, 1'b0);
    push_letter(int'(pf_pkg::LETTER_J), 1'b0);      // J folds into I, so J I doubles
    push_letter(int'(pf_pkg::LETTER_I), 1'b0);
    push_letter(int'(pf_pkg::LETTER_I), 1'b1);      // doubled again at the end
    push_letter(int'(pf_pkg::LETTER_X), 1'b0);      // X X doubles into the XX digraph
    push_letter(int'(pf_pkg::LETTER_X), 1'b0);
    push_letter(5, 1'b1);
    push_letter(31, 1'b0);                          // codes outside the alphabet
    push_letter(26, 1'b1);
    push_letter(4, 1'b1);                           // lone letter closing a message
    push_letter(int'(plan_cells[0]), 1'b0);         // same row
    push_letter(int'(plan_cells[1]), 1'b0);
    push_letter(int'(plan_cells[0]), 1'b0);         // same column
    push_letter(int'(plan_cells[pf_pkg::SIDE]), 1'b0);
    push_letter(int'(plan_cells[0]), 1'b0);         // rectangle
    push_letter(int'(plan_cells[pf_pkg::SIDE+1]), 1'b1);
    push_letter(17, 1'b1);
    wait_drained();

    // Same square decrypting, with a long output hold-off at the start.
    write_reg(pf_pkg::REG_MODE, pf_pkg::CFG_W'(1));
    key_settings++;
    hold_req++;
    queue_messages(120);
    wait_drained();

    plan_permuted_square();
    load_square(1'b0);
    queue_messages(100);
    wait_drained();

    // All registers written with ones: every cell holds code 31, decrypting.
    write_reg(pf_pkg::REG_UPPER, '1);
    write_reg(pf_pkg::REG_MIDDLE, '1);
    write_reg(pf_pkg::REG_BOTTOM, '1);
    write_reg(pf_pkg::REG_MODE, '1);
    key_settings++;
    queue_messages(12);
    wait_drained();

    // Arbitrary cell codes: duplicates and codes beyond Z in the square.
    for (int k = 0; k < pf_pkg::CELLS; k++) begin
      plan_cells[k] = pf_pkg::CODE_W'($urandom_range(0, 31));
    end
    load_square(1'b0);
    queue_messages(80);
    wait_drained();

    // Final stretch at full rate on both sides.
    quiet = 1'b1;
    plan_permuted_square();
    load_square(1'b1);
    queue_messages(100);
    wait_drained();

    $display("Run covered %0d letters and %0d digraphs over %0d key square settings,",
             letters_accepted, digraphs_checked, key_settings);
    $display("in both directions, with random idling, stalls and one long hold-off.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d of %0d letters taken, %0d digraphs still expected",
             letters_accepted, letters_queued, expected_digraphs.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
